### hw/rtl/apm_pkg.sv
// shared types and constants of the audio peak and rms level meter
package apm_pkg;

  // window length register
  localparam int unsigned WINDOW_BITS = 20;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 20'd48000;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_ROOT_INIT,
    S_ROOT,
    S_OUT
  } apm_state_t;

  // accumulator controls
  typedef struct packed {
    logic take;
    logic square;
    logic add;
    logic clear;
  } acc_ctrl_t;

  // divide and root engine controls
  typedef struct packed {
    logic load;
    logic div_step;
    logic root_init;
    logic root_step;
  } itr_ctrl_t;

endpackage

### hw/rtl/audio_peak_rms_meter.sv
// Audio peak and RMS level meter. Each accepted PCM sample passes through the
// capture, square and accumulate states; in_stall is high in every state after
// the transfer until the sequencer is back in idle, so a new sample is taken only
// once the last one is through. The sample that completes a window (count
// reaching window_len; a length of zero acts as one) adds a load step, a
// restoring division of the sum of squares by the count, a setup step and a
// square root, all on one shared subtractor, then a step to move the result
// into the output register. The sum of squares is SUM_W bits wide
// (SUM_W = 2*SAMPLE_BITS-1+COUNT_BITS, at most 64). A finished result may
// wait in the output register while the next window accumulates; a second one
// holds the block until the first is taken. cfg_ready is always high.
module audio_peak_rms_meter #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SAMPLE_BITS-1:0]          out_peak_level,
  output logic [SAMPLE_BITS-1:0]          out_rms_level,
  output logic [COUNT_BITS-1:0]           out_window_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apm_pkg::WINDOW_BITS-1:0] cfg_window_len
);

  import apm_pkg::*;

  localparam int unsigned SUM_FULL = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
  localparam int unsigned SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
  localparam int unsigned ROOT_W   = (SUM_W + 1) / 2;
  localparam int unsigned UNIT_W   = (COUNT_BITS + 1 > ROOT_W + 2) ? COUNT_BITS + 1 : ROOT_W + 2;
  localparam int unsigned STEP_W   = $clog2(SUM_W + 1);

  apm_state_t state_r;
  apm_state_t state_nxt;

  logic [STEP_W-1:0]      step_r;
  logic [STEP_W-1:0]      step_nxt;
  logic [WINDOW_BITS-1:0] window_len_r;
  logic [SAMPLE_BITS-1:0] win_peak_r;

  acc_ctrl_t              acc_ctrl;
  itr_ctrl_t              itr_ctrl;
  logic                   load_out;
  logic                   in_xfer;
  logic                   out_free;
  logic                   div_last;
  logic                   root_last;

  logic                   acc_close;
  logic [SAMPLE_BITS-1:0] acc_peak;
  logic [SUM_W-1:0]       acc_sum;
  logic [COUNT_BITS-1:0]  acc_count;
  logic [ROOT_W-1:0]      root;
  logic [COUNT_BITS-1:0]  divisor_held;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_peak_r;
  logic [SAMPLE_BITS-1:0] out_rms_r;
  logic [COUNT_BITS-1:0]  out_count_r;

  assign in_xfer   = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign div_last  = (step_r == STEP_W'(SUM_W - 1));
  assign root_last = (step_r == STEP_W'(ROOT_W - 1));

  // window length register, written on a cfg transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_len_r <= cfg_window_len;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_xfer) state_nxt = S_SQUARE;
      S_SQUARE:    state_nxt = S_ADD;
      S_ADD:       state_nxt = acc_close ? S_LOAD : S_IDLE;
      S_LOAD:      state_nxt = S_DIV;
      S_DIV:       if (div_last) state_nxt = S_ROOT_INIT;
      S_ROOT_INIT: state_nxt = S_ROOT;
      S_ROOT:      if (root_last) state_nxt = S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // step counter of the divide and root phases
  always_comb begin
    case (state_r)
      S_DIV,
      S_ROOT:  step_nxt = step_r + 1'b1;
      default: step_nxt = '0;
    endcase
  end

  // sequencer outputs
  always_comb begin
    acc_ctrl = '0;
    itr_ctrl = '0;
    load_out = 1'b0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        acc_ctrl.take = in_valid;
      end
      S_SQUARE:    acc_ctrl.square = 1'b1;
      S_ADD:       acc_ctrl.add = 1'b1;
      S_LOAD: begin
        itr_ctrl.load  = 1'b1;
        acc_ctrl.clear = 1'b1;
      end
      S_DIV:       itr_ctrl.div_step = 1'b1;
      S_ROOT_INIT: itr_ctrl.root_init = 1'b1;
      S_ROOT:      itr_ctrl.root_step = 1'b1;
      S_OUT:       load_out = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // window peak kept while the engine works
  always_ff @(posedge clk) begin
    if (itr_ctrl.load) begin
      win_peak_r <= acc_peak;
    end
  end

  apm_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SUM_W       (SUM_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (acc_ctrl),
    .in_sample  (in_sample),
    .window_len (window_len_r),
    .close      (acc_close),
    .peak       (acc_peak),
    .sum        (acc_sum),
    .count      (acc_count)
  );

  apm_iter #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_W      (SUM_W),
    .ROOT_W     (ROOT_W),
    .UNIT_W     (UNIT_W)
  ) u_iter (
    .clk          (clk),
    .ctrl         (itr_ctrl),
    .dividend     (acc_sum),
    .divisor      (acc_count),
    .root         (root),
    .divisor_held (divisor_held)
  );

  // output register
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_peak_r  <= win_peak_r;
      out_rms_r   <= root[SAMPLE_BITS-1:0];
      out_count_r <= divisor_held;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_peak_level   = out_peak_r;
  assign out_rms_level    = out_rms_r;
  assign out_window_count = out_count_r;

`ifndef NO_ASSERTIONS
  // a delivered window always covers at least one sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_count != '0))
    else $error("result with empty window");

  // the mean square never exceeds the square of the peak
  a_rms_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rms_level <= out_peak_level))
    else $error("rms level above peak level");

  // accumulators are empty once the window has been handed to the engine
  a_accum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (acc_count == '0 && acc_peak == '0))
    else $error("accumulators not cleared after window close");
`endif

endmodule

### hw/rtl/apm_trial_sub.sv
// shared trial subtractor for the divide and root steps
module apm_trial_sub #(
  parameter int unsigned WIDTH = 28
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             ge,
  output logic [WIDTH-1:0] diff
);

  logic borrow;

  // subtract with borrow out, no borrow means a >= b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

### hw/rtl/apm_accum.sv
// peak, sum of squares and sample count accumulators
module apm_accum #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20,
  parameter int unsigned SUM_W       = 51
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  apm_pkg::acc_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic [apm_pkg::WINDOW_BITS-1:0]     window_len,
  output logic                                close,
  output logic [SAMPLE_BITS-1:0]              peak,
  output logic [SUM_W-1:0]                    sum,
  output logic [COUNT_BITS-1:0]               count
);

  import apm_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > WINDOW_BITS) ? COUNT_BITS : WINDOW_BITS;

  logic [SAMPLE_BITS-1:0]   raw;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [SAMPLE_BITS-1:0]   mag_r;
  logic [2*SAMPLE_BITS-1:0] sq_r;
  logic [SAMPLE_BITS-1:0]   peak_r;
  logic [SUM_W-1:0]         sum_r;
  logic [COUNT_BITS-1:0]    count_r;
  logic [COUNT_BITS-1:0]    cnt_inc;
  logic                     close_r;

  // magnitude, most negative sample wraps to its exact unsigned magnitude
  always_comb begin
    raw = in_sample;
    mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  end

  assign cnt_inc = count_r + 1'b1;

  // sample capture and squaring
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      mag_r <= mag;
    end
    if (ctrl.square) begin
      sq_r <= mag_r * mag_r;
    end
  end

  // running accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      sum_r   <= '0;
      count_r <= '0;
      close_r <= 1'b0;
    end else if (ctrl.clear) begin
      peak_r  <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      if (ctrl.square) begin
        if (mag_r > peak_r) begin
          peak_r <= mag_r;
        end
        count_r <= cnt_inc;
        close_r <= CMP_W'(cnt_inc) >= CMP_W'(window_len);
      end
      if (ctrl.add) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
    end
  end

  assign close = close_r;
  assign peak  = peak_r;
  assign sum   = sum_r;
  assign count = count_r;

endmodule

### hw/rtl/apm_iter.sv
// restoring divider and digit-by-digit square root over one shared subtractor
module apm_iter #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned SUM_W      = 51,
  parameter int unsigned ROOT_W     = 26,
  parameter int unsigned UNIT_W     = 28
) (
  input  logic                  clk,
  input  apm_pkg::itr_ctrl_t    ctrl,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [ROOT_W-1:0]     root,
  output logic [COUNT_BITS-1:0] divisor_held
);

  import apm_pkg::*;

  localparam int unsigned QW  = 2 * ROOT_W;
  localparam int unsigned PAD = QW - SUM_W;

  logic [QW-1:0]         q_r;
  logic [UNIT_W-1:0]     rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [COUNT_BITS-1:0] dsr_r;
  logic                  dsr_nz_r;
  logic [UNIT_W-1:0]     a_div;
  logic [UNIT_W-1:0]     b_div;
  logic [UNIT_W-1:0]     a_root;
  logic [UNIT_W-1:0]     b_root;
  logic [UNIT_W-1:0]     op_a;
  logic [UNIT_W-1:0]     op_b;
  logic [UNIT_W-1:0]     diff;
  logic                  ge;
  logic                  ge_div;

  // operands of one divide step and of one root step
  assign a_div  = UNIT_W'({rem_r[COUNT_BITS-1:0], q_r[QW-1]});
  assign b_div  = UNIT_W'(dsr_r);
  assign a_root = UNIT_W'({rem_r[ROOT_W-1:0], q_r[QW-1:QW-2]});
  assign b_root = UNIT_W'({root_r[ROOT_W-2:0], 2'b01});

  assign op_a = ctrl.div_step ? a_div : a_root;
  assign op_b = ctrl.div_step ? b_div : b_root;

  apm_trial_sub #(
    .WIDTH (UNIT_W)
  ) u_sub (
    .a    (op_a),
    .b    (op_b),
    .ge   (ge),
    .diff (diff)
  );

  // a zero count gives a zero quotient
  assign ge_div = ge & dsr_nz_r;

  // quotient shifts in at the bottom while the dividend leaves at the top,
  // then the root consumes the quotient two bits at a time
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_r      <= QW'(dividend) << PAD;
      dsr_r    <= divisor;
      dsr_nz_r <= |divisor;
      rem_r    <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= ge_div ? diff : op_a;
      q_r   <= {q_r[QW-2:0], ge_div};
    end else if (ctrl.root_init) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctrl.root_step) begin
      rem_r  <= ge ? diff : op_a;
      root_r <= {root_r[ROOT_W-2:0], ge};
      q_r    <= {q_r[QW-3:0], 2'b00};
    end
  end

  assign root         = root_r;
  assign divisor_held = dsr_r;

endmodule

### dv/audio_peak_rms_meter_tb.sv
// self-checking testbench for the audio peak and rms level meter
module audio_peak_rms_meter_tb;
  import apm_pkg::*;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned COUNT_BITS    = 20;
  localparam int unsigned SUM_BITS      = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
  // idle wait after the results, longer than the longest window close
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned RANDOM_ITEMS  = 890;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = '1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [SAMPLE_BITS-1:0] rms;
    logic [COUNT_BITS-1:0]  count;
  } level_result_t;

  // floor square root, one bit per pass from the top
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // level predictor and queue of awaited results
  class level_scoreboard;
    logic [WINDOW_BITS-1:0] window_len;
    logic [SAMPLE_BITS-1:0] peak_hold;
    logic [SUM_BITS-1:0]    sum_sq;
    logic [COUNT_BITS-1:0]  count;
    level_result_t          awaited[$];
    int unsigned            failures;
    int unsigned            samples_in;
    int unsigned            results_out;

    function new();
      window_len  = WINDOW_RESET;
      peak_hold   = '0;
      sum_sq      = '0;
      count       = '0;
      failures    = 0;
      samples_in  = 0;
      results_out = 0;
    endfunction

    function void set_window(input logic [WINDOW_BITS-1:0] len);
      window_len = len;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // accumulate one accepted sample, close the window when due
    function void note_sample(input logic signed [SAMPLE_BITS-1:0] pcm);
      logic [SAMPLE_BITS:0] mag;
      logic [63:0]          mean;
      level_result_t        r;
      samples_in++;
      // most negative sample keeps its full magnitude, negated one bit wider
      mag = pcm[SAMPLE_BITS-1] ? (~{pcm[SAMPLE_BITS-1], pcm} + 1'b1) : {1'b0, pcm};
      if (mag > peak_hold) peak_hold = mag[SAMPLE_BITS-1:0];
      sum_sq = sum_sq + mag * mag;
      count  = count + 1'b1;
      // a window length of zero closes on every sample
      if (count < window_len) return;
      mean    = 64'(sum_sq) / 64'(count);
      r.peak  = peak_hold;
      r.rms   = SAMPLE_BITS'(floor_sqrt(mean));
      r.count = count;
      awaited.push_back(r);
      peak_hold = '0;
      sum_sq    = '0;
      count     = '0;
    endfunction

    // compare one result transfer with the oldest awaited result
    function void check_result(input level_result_t got);
      level_result_t want;
      results_out++;
      if (awaited.size() == 0) begin
        $error("unexpected result: peak_level %0d rms_level %0d window_count %0d",
               got.peak, got.rms, got.count);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.peak != want.peak) begin
        $error("peak_level mismatch: expected %0d, got %0d", want.peak, got.peak);
        failures++;
      end
      if (got.rms != want.rms) begin
        $error("rms_level mismatch: expected %0d, got %0d", want.rms, got.rms);
        failures++;
      end
      if (got.count != want.count) begin
        $error("window_count mismatch: expected %0d, got %0d", want.count, got.count);
        failures++;
      end
    endfunction

    function void finish_check();
      if (awaited.size() != 0) begin
        $error("%0d results never arrived", awaited.size());
        failures++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic signed [SAMPLE_BITS-1:0]   in_sample;
  logic                            out_valid;
  logic                            out_stall;
  logic [SAMPLE_BITS-1:0]          out_peak_level;
  logic [SAMPLE_BITS-1:0]          out_rms_level;
  logic [COUNT_BITS-1:0]           out_window_count;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [WINDOW_BITS-1:0]          cfg_window_len;

  level_scoreboard sb = new();
  bit              hold_request;
  int unsigned     send_burst;
  int unsigned     window_writes;
  int unsigned     cycle_count;

  audio_peak_rms_meter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_peak_level   (out_peak_level),
    .out_rms_level    (out_rms_level),
    .out_window_count (out_window_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_len   (cfg_window_len)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("audio_peak_rms_meter verification failed");
    $finish;
  end

  // idle length per transfer, with occasional runs of back-to-back traffic
  function automatic int unsigned draw_gap(inout int unsigned burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // mix of full-scale extremes, quiet samples and uniform noise
  function automatic logic signed [SAMPLE_BITS-1:0] draw_pcm();
    case ($urandom_range(0, 7))
      0: return SAMPLE_BITS'(-32768);
      1: return SAMPLE_BITS'(32767);
      2: return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // one sample transfer on the input channel
  task automatic send_pcm(input logic signed [SAMPLE_BITS-1:0] pcm);
    int unsigned gap;
    gap = draw_gap(send_burst);
    repeat (gap) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      in_sample <= SAMPLE_BITS'($urandom);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= pcm;
    do @(posedge clk); while (in_stall);
    sb.note_sample(pcm);
  endtask

  // stop offering samples and let every awaited result come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // window length register write
  task automatic write_window(input logic [WINDOW_BITS-1:0] len);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_window_len <= len;
    do @(posedge clk); while (!cfg_ready);
    sb.set_window(len);
    window_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, long hold-off on request
  initial begin : result_sink
    int unsigned   hold;
    int unsigned   burst_left;
    bit            hold_taken;
    level_result_t got;
    hold       = 0;
    burst_left = 0;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.peak  = out_peak_level;
        got.rms   = out_rms_level;
        got.count = out_window_count;
        sb.check_result(got);
        hold = draw_gap(burst_left);
      end
      if (hold_request && !hold_taken) begin
        hold       = LONG_HOLD;
        hold_taken = 1'b1;
      end
      @(negedge clk);
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [WINDOW_BITS-1:0] w;
    int unsigned            phase_items;
    int unsigned            sent;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    cfg_valid      = 1'b0;
    cfg_window_len = '0;
    hold_request   = 1'b0;
    send_burst     = 0;
    window_writes  = 0;
    sent           = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset window length: partial window, closed later by a shorter one
    send_pcm(0);
    send_pcm(32767);
    send_pcm(-32768);
    send_pcm(-1);
    send_pcm(1);
    send_pcm(16384);
    send_pcm(-32767);
    settle();
    write_window(3);
    send_pcm(-32768);

    // one sample per window
    settle();
    write_window(1);
    send_pcm(-32768);
    send_pcm(32767);
    send_pcm(0);
    send_pcm(-1);

    // zero length acts as one
    settle();
    write_window('0);
    send_pcm(5);
    send_pcm(-32768);
    send_pcm(3);

    // longest window, then cut short mid-window
    settle();
    write_window(WINDOW_MAX);
    send_pcm(32767);
    send_pcm(-32768);
    send_pcm(32767);
    send_pcm(-32768);
    send_pcm(-32768);
    settle();
    write_window(2);
    send_pcm(1);

    // full-scale negative window: rms at its top value
    settle();
    write_window(4);
    repeat (4) send_pcm(-32768);

    // receiver holds off while one-sample windows keep coming
    settle();
    write_window(1);
    hold_request = 1'b1;
    repeat (40) send_pcm(draw_pcm());

    // random windows and content; leftover counts exercise shortened windows
    while (sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = 1;
        2: w = WINDOW_MAX;
        3: w = WINDOW_BITS'($urandom_range(17, 64));
        default: w = WINDOW_BITS'($urandom_range(2, 16));
      endcase
      write_window(w);
      if (w == WINDOW_MAX) phase_items = $urandom_range(1, 20);
      else phase_items = $urandom_range(1, 3 * w + 4);
      repeat (phase_items) begin
        send_pcm(draw_pcm());
        sent++;
      end
    end

    settle();
    sb.finish_check();
    $display("run covered %0d samples and %0d level results across %0d window settings",
             sb.samples_in, sb.results_out, window_writes);
    if (sb.failures == 0) begin
      $display("audio_peak_rms_meter verification clean");
    end else begin
      $display("audio_peak_rms_meter verification failed");
    end
    $finish;
  end

endmodule

### audio_peak_rms_meter.f
hw/rtl/apm_pkg.sv
hw/rtl/apm_trial_sub.sv
hw/rtl/apm_accum.sv
hw/rtl/apm_iter.sv
hw/rtl/audio_peak_rms_meter.sv
dv/audio_peak_rms_meter_tb.sv
